FILE: design/mqe_pkg.sv
// Shared types, constants and probability tables of the MQ arithmetic encoder.
// Used by every module of the encoder but mqe_ram; depends on nothing.
package mqe_pkg;

    localparam int NUM_CONTEXTS_DEF = 19;
    localparam int CTX_FIELD_W      = 5;
    localparam int ENTRY_W          = 7;
    localparam int A_W              = 16;
    localparam int C_W              = 28;
    localparam int MAX_BYTES        = 8;

    localparam logic [A_W-1:0] A_INIT      = 16'h8000;
    localparam logic [3:0]     BC_INIT     = 4'd12;
    localparam logic [5:0]     ST_MAX      = 6'd46;
    localparam logic [4:0]     SEG_CTX     = 5'd18;

    typedef enum logic [2:0] {
        OP_INIT   = 3'd0,
        OP_ENCODE = 3'd1,
        OP_FLUSH  = 3'd2,
        OP_ERTERM = 3'd3,
        OP_RSTCTX = 3'd4,
        OP_SEGMARK = 3'd5
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_EVAL,
        ST_REN,
        ST_REN_CHK,
        ST_NEXT,
        ST_BO,
        ST_FL_PREP,
        ST_FL_SH1,
        ST_FL_SH2,
        ST_FL_END,
        ST_ET_LOOP,
        ST_ET_CHK,
        ST_ET_END,
        ST_FAKE,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic [CTX_FIELD_W-1:0] rd_addr;
        logic                   wr_en;
        logic [CTX_FIELD_W-1:0] wr_addr;
        logic [ENTRY_W-1:0]     wr_data;
        logic                   clr;
    } ctx_req_t;

    localparam logic [15:0] QE_TAB [0:46] = '{
        16'h5601, 16'h3401, 16'h1801, 16'h0AC1, 16'h0521, 16'h0221, 16'h5601, 16'h5401,
        16'h4801, 16'h3801, 16'h3001, 16'h2401, 16'h1C01, 16'h1601, 16'h5601, 16'h5401,
        16'h5101, 16'h4801, 16'h3801, 16'h3401, 16'h3001, 16'h2801, 16'h2401, 16'h2201,
        16'h1C01, 16'h1801, 16'h1601, 16'h1401, 16'h1201, 16'h1101, 16'h0AC1, 16'h09C1,
        16'h08A1, 16'h0521, 16'h0441, 16'h02A1, 16'h0221, 16'h0141, 16'h0111, 16'h0085,
        16'h0049, 16'h0025, 16'h0015, 16'h0009, 16'h0005, 16'h0001, 16'h5601
    };
    localparam logic [5:0] NMPS_TAB [0:46] = '{
        6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd38, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12,
        6'd13, 6'd29, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23,
        6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd34,
        6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40, 6'd41, 6'd42, 6'd43, 6'd44, 6'd45,
        6'd45, 6'd46
    };
    localparam logic [5:0] NLPS_TAB [0:46] = '{
        6'd1, 6'd6, 6'd9, 6'd12, 6'd29, 6'd33, 6'd6, 6'd14, 6'd14, 6'd14, 6'd17, 6'd18,
        6'd20, 6'd21, 6'd14, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd19, 6'd20,
        6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31,
        6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40, 6'd41, 6'd42,
        6'd43, 6'd46
    };

    function automatic logic switch_mps(input logic [5:0] st);
        return (st == 6'd0) || (st == 6'd6) || (st == 6'd14);
    endfunction

    function automatic logic [ENTRY_W-1:0] ctx_init(input logic [CTX_FIELD_W-1:0] idx);
        logic [ENTRY_W-1:0] v;
        unique case (idx)
            5'd0:    v = {6'd4, 1'b0};
            5'd17:   v = {6'd3, 1'b0};
            5'd18:   v = {6'd46, 1'b0};
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: design/mqe_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module mqe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: design/mqe_ctx_store.sv
// Context store: probability state and MPS sense per context, held in a RAM,
// with per-entry valid bits that return unwritten entries to their reset value.
// Depends on mqe_pkg and mqe_ram.
module mqe_ctx_store
    import mqe_pkg::*;
#(
    parameter int NUM_CONTEXTS = NUM_CONTEXTS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ctx_req_t           req,
    output logic [ENTRY_W-1:0] rdata
);
    localparam int CW = $clog2(NUM_CONTEXTS);

    logic [NUM_CONTEXTS-1:0] vld_reg;
    logic                    rd_vld_reg;
    logic [CTX_FIELD_W-1:0]  rd_addr_reg;
    logic [ENTRY_W-1:0]      ram_q;

    mqe_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_CONTEXTS)) u_ram (
        .aclk  (aclk),
        .we    (req.wr_en),
        .waddr (req.wr_addr[CW-1:0]),
        .wdata (req.wr_data),
        .raddr (req.rd_addr[CW-1:0]),
        .rdata (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn || req.clr) begin
            vld_reg <= '0;
        end else if (req.wr_en) begin
            vld_reg[req.wr_addr[CW-1:0]] <= 1'b1;
        end
        rd_vld_reg  <= vld_reg[req.rd_addr[CW-1:0]];
        rd_addr_reg <= req.rd_addr;
    end

    assign rdata = rd_vld_reg ? ram_q : ctx_init(rd_addr_reg);
endmodule

FILE: design/mqe_coder.sv
// Coding sequencer: interval and code registers, renormalisation, byte output
// with carry and stuffing, flush and ERTERM termination, and the output register.
// Depends on mqe_pkg.
module mqe_coder
    import mqe_pkg::*;
#(
    parameter int NUM_CONTEXTS = NUM_CONTEXTS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [2:0]             in_op,
    input  logic [CTX_FIELD_W-1:0] in_ctx,
    input  logic                   in_bit,
    output ctx_req_t               ctx_req,
    input  logic [ENTRY_W-1:0]     ctx_rdata,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             out_byte,
    output logic                   out_last
);
    seq_state_t state_reg, state_next, ret_reg, ret_next;
    logic [A_W-1:0] a_reg, a_next;
    logic [C_W-1:0] c_reg, c_next;
    logic [3:0] bc_reg, bc_next;
    logic [7:0] held_reg, held_next;
    logic real_reg, real_next;
    logic [CTX_FIELD_W-1:0] ctx_reg, ctx_next;
    logic bit_reg, bit_next;
    logic [1:0] seg_reg, seg_next;
    logic [4:0] guard_reg, guard_next;
    logic signed [4:0] k_reg, k_next;
    logic [3:0] cnt_reg, cnt_next;
    logic pend_v_reg, pend_v_next;
    logic [7:0] pend_reg, pend_next;
    logic ov_reg, ov_next;
    logic [7:0] ob_reg, ob_next;
    logic ol_reg, ol_next;

    logic out_free, push_req, emit, stall;
    logic [7:0] push_byte;
    logic [5:0] st;
    logic mps;
    logic [15:0] qe, a1;
    logic [A_W-1:0] a_sh;
    logic [3:0] bc_dec;
    logic [4:0] g_inc;
    logic bo_seven, bo_inc;
    logic [7:0] bo_hb;
    logic [C_W-1:0] bo_c;
    logic [29:0] fl_top;
    logic [C_W-1:0] fl_cor;

    assign out_free  = !ov_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = ov_reg;
    assign out_byte  = ob_reg;
    assign out_last  = ol_reg;

    assign st  = (ctx_rdata[6:1] > ST_MAX) ? ST_MAX : ctx_rdata[6:1];
    assign mps = ctx_rdata[0];
    assign qe  = QE_TAB[st];
    assign a1  = a_reg - qe;
    assign a_sh   = {a_reg[A_W-2:0], 1'b0};
    assign bc_dec = bc_reg - 4'd1;
    assign g_inc  = guard_reg + 5'd1;

    assign bo_inc   = (held_reg != 8'hFF) && c_reg[27];
    assign bo_hb    = held_reg + {7'd0, bo_inc};
    assign bo_seven = (held_reg == 8'hFF) || (bo_inc && bo_hb == 8'hFF);
    assign bo_c     = (bo_inc && bo_hb == 8'hFF) ? {1'b0, c_reg[26:0]} : c_reg;

    assign fl_top = {2'b00, c_reg} + {14'd0, a_reg};
    assign fl_cor = c_reg | 28'hFFFF;

    always_comb begin
        push_req  = 1'b0;
        push_byte = held_reg;
        if (state_reg == ST_BO) begin
            push_req  = real_reg;
            push_byte = bo_hb;
        end else if (state_reg == ST_FL_END) begin
            push_req = real_reg && (held_reg != 8'hFF);
        end
    end
    assign emit  = push_req && (cnt_reg < 4'(MAX_BYTES));
    assign stall = emit && pend_v_reg && !out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ret_reg    <= ST_IDLE;
            a_reg      <= A_INIT;
            c_reg      <= '0;
            bc_reg     <= BC_INIT;
            held_reg   <= '0;
            real_reg   <= 1'b0;
            seg_reg    <= '0;
            guard_reg  <= '0;
            k_reg      <= '0;
            cnt_reg    <= '0;
            pend_v_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            a_reg      <= a_next;
            c_reg      <= c_next;
            bc_reg     <= bc_next;
            held_reg   <= held_next;
            real_reg   <= real_next;
            seg_reg    <= seg_next;
            guard_reg  <= guard_next;
            k_reg      <= k_next;
            cnt_reg    <= cnt_next;
            pend_v_reg <= pend_v_next;
            ov_reg     <= ov_next;
        end
        ctx_reg  <= ctx_next;
        bit_reg  <= bit_next;
        pend_reg <= pend_next;
        ob_reg   <= ob_next;
        ol_reg   <= ol_next;
    end

    always_comb begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        a_next      = a_reg;
        c_next      = c_reg;
        bc_next     = bc_reg;
        held_next   = held_reg;
        real_next   = real_reg;
        ctx_next    = ctx_reg;
        bit_next    = bit_reg;
        seg_next    = seg_reg;
        guard_next  = guard_reg;
        k_next      = k_reg;
        cnt_next    = cnt_reg;
        pend_v_next = pend_v_reg;
        pend_next   = pend_reg;
        ob_next     = ob_reg;
        ol_next     = ol_reg;
        ov_next     = ov_reg && !out_ready;
        ctx_req         = '0;
        ctx_req.rd_addr = ctx_reg;
        ctx_req.wr_addr = ctx_reg;

        if (emit && !stall) begin
            cnt_next    = cnt_reg + 4'd1;
            pend_v_next = 1'b1;
            pend_next   = push_byte;
            if (pend_v_reg) begin
                ov_next = 1'b1;
                ob_next = pend_reg;
                ol_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cnt_next   = '0;
                    ctx_next   = in_ctx;
                    bit_next   = in_bit;
                    seg_next   = '0;
                    guard_next = '0;
                    unique case (in_op)
                        OP_INIT: begin
                            a_next    = A_INIT;
                            c_next    = '0;
                            bc_next   = BC_INIT;
                            held_next = '0;
                            real_next = 1'b0;
                        end
                        OP_ENCODE: begin
                            if ({1'b0, in_ctx} < (CTX_FIELD_W+1)'(NUM_CONTEXTS)) begin
                                state_next = ST_RD;
                            end
                        end
                        OP_FLUSH: state_next = ST_FL_PREP;
                        OP_ERTERM: begin
                            k_next     = 5'sd12 - $signed({1'b0, bc_reg});
                            state_next = ST_ET_LOOP;
                        end
                        OP_RSTCTX: ctx_req.clr = 1'b1;
                        OP_SEGMARK: begin
                            ctx_next   = SEG_CTX;
                            bit_next   = 1'b1;
                            seg_next   = 2'd3;
                            state_next = ST_RD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RD: begin
                guard_next = '0;
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                state_next = ST_REN;
                if (mps == bit_reg) begin
                    ctx_req.wr_data = {NMPS_TAB[st], mps};
                    if (!a1[15]) begin
                        ctx_req.wr_en = 1'b1;
                        if (a1 < qe) begin
                            a_next = qe;
                        end else begin
                            a_next = a1;
                            c_next = c_reg + {12'd0, qe};
                        end
                    end else begin
                        a_next     = a1;
                        c_next     = c_reg + {12'd0, qe};
                        state_next = ST_NEXT;
                    end
                end else begin
                    ctx_req.wr_en   = 1'b1;
                    ctx_req.wr_data = {NLPS_TAB[st], mps ^ switch_mps(st)};
                    if (a1 < qe) begin
                        a_next = a1;
                        c_next = c_reg + {12'd0, qe};
                    end else begin
                        a_next = qe;
                    end
                end
            end
            ST_REN: begin
                a_next     = a_sh;
                c_next     = {c_reg[C_W-2:0], 1'b0};
                bc_next    = bc_dec;
                guard_next = g_inc;
                if (bc_dec == 4'd0) begin
                    ret_next   = ST_REN_CHK;
                    state_next = ST_BO;
                end else if (!a_sh[15] && g_inc < 5'd16) begin
                    state_next = ST_REN;
                end else begin
                    state_next = ST_NEXT;
                end
            end
            ST_REN_CHK: begin
                state_next = (!a_reg[15] && guard_reg < 5'd16) ? ST_REN : ST_NEXT;
            end
            ST_NEXT: begin
                if (seg_reg != 2'd0) begin
                    seg_next   = seg_reg - 2'd1;
                    bit_next   = !bit_reg;
                    state_next = ST_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_BO: begin
                if (!stall) begin
                    real_next  = 1'b1;
                    state_next = ret_reg;
                    if (bo_seven) begin
                        held_next = bo_c[27:20];
                        c_next    = {8'd0, bo_c[19:0]};
                        bc_next   = 4'd7;
                    end else begin
                        held_next = bo_c[26:19];
                        c_next    = {9'd0, bo_c[18:0]};
                        bc_next   = 4'd8;
                    end
                end
            end
            ST_FL_PREP: begin
                c_next     = ({2'b00, fl_cor} >= fl_top) ? fl_cor - 28'h8000 : fl_cor;
                state_next = ST_FL_SH1;
            end
            ST_FL_SH1: begin
                c_next     = c_reg << bc_reg;
                ret_next   = ST_FL_SH2;
                state_next = ST_BO;
            end
            ST_FL_SH2: begin
                c_next     = c_reg << bc_reg;
                ret_next   = ST_FL_END;
                state_next = ST_BO;
            end
            ST_FL_END: begin
                if (!stall) begin
                    held_next  = '0;
                    real_next  = 1'b0;
                    state_next = ST_DONE;
                end
            end
            ST_ET_LOOP: begin
                if (k_reg > 5'sd0 && guard_reg < 5'd4) begin
                    c_next     = c_reg << bc_reg;
                    bc_next    = 4'd0;
                    guard_next = g_inc;
                    ret_next   = ST_ET_CHK;
                    state_next = ST_BO;
                end else begin
                    state_next = ST_ET_END;
                end
            end
            ST_ET_CHK: begin
                k_next     = k_reg - $signed({1'b0, bc_reg});
                state_next = ST_ET_LOOP;
            end
            ST_ET_END: begin
                ret_next   = ST_FAKE;
                state_next = (held_reg != 8'hFF) ? ST_BO : ST_FAKE;
            end
            ST_FAKE: begin
                held_next  = '0;
                real_next  = 1'b0;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!pend_v_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    ov_next     = 1'b1;
                    ob_next     = pend_reg;
                    ol_next     = 1'b1;
                    pend_v_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

FILE: design/mq_arithmetic_encoder_core.sv
// MQ arithmetic encoder, one word at a time: init, context reset and ignored words finish in idle;
// an encode or a segmark reads its context and evaluates, then renormalises with any code bytes;
// a flush prepares C and shifts out bytes; an ERTERM loops over bytes and may put out a last one.
// A result that waits on m_tready stalls the sequencer until it is taken.
// Reset (synchronous, active low) sets A = 0x8000, C = 0, bit count 12, a fake
// held byte, and all contexts to their initial states through per-entry valid bits.
module mq_arithmetic_encoder_core
    import mqe_pkg::*;
#(
    parameter int NUM_CONTEXTS = NUM_CONTEXTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // op[2:0], ctx[7:3], bit_req[8], zeros above
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic        m_tlast
);
    ctx_req_t           ctx_req;
    logic [ENTRY_W-1:0] ctx_rdata;

    mqe_ctx_store #(.NUM_CONTEXTS(NUM_CONTEXTS)) u_ctx (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ctx_req),
        .rdata   (ctx_rdata)
    );

    mqe_coder #(.NUM_CONTEXTS(NUM_CONTEXTS)) u_coder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tdata[2:0]),
        .in_ctx    (s_tdata[7:3]),
        .in_bit    (s_tdata[8]),
        .ctx_req   (ctx_req),
        .ctx_rdata (ctx_rdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );
endmodule
